[src/shs_pkg.sv]
// Package with the types, constants and helper functions of the SHA-256 stream hasher.
`default_nettype none

package shs_pkg;

    localparam int unsigned C_WORD_W  = 32;
    localparam int unsigned C_BYTE_W  = 8;
    localparam int unsigned C_COUNT_W = 61;
    localparam int unsigned C_IDX_W   = 3;

    typedef logic [C_WORD_W-1:0] t_word;
    typedef t_word t_vars [8];
    typedef t_word t_sched [16];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic [5:0] C_POS_LAST = 6'h3F;
    localparam logic [2:0] C_IDX_LAST = 3'd7;

    localparam t_word C_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word C_ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic t_word f_rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (C_WORD_W - n));
    endfunction

endpackage

`default_nettype wire

[src/shs_if.sv]
// Valid/ready channel interfaces for the input bytes and the digest words.
`default_nettype none

interface shs_in_if;
    import shs_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_BYTE_W-1:0] data_byte;
    logic                byte_valid;
    logic                last;

    modport source (output valid, output data_byte, output byte_valid, output last,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

interface shs_out_if;
    import shs_pkg::*;

    logic               valid;
    logic               ready;
    t_word              digest_word;
    logic [C_IDX_W-1:0] word_index;
    logic               last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

[src/shs_round.sv]
// One SHA-256 compression round together with one step of the message schedule.
`default_nettype none

module shs_round (
    input  shs_pkg::t_vars  i_vars,
    input  shs_pkg::t_sched i_w,
    input  shs_pkg::t_word  i_k,
    output shs_pkg::t_vars  o_vars,
    output shs_pkg::t_word  o_new_w
);
    import shs_pkg::*;

    t_word w_sig1;
    t_word w_ch;
    t_word w_sig0;
    t_word w_maj;
    t_word w_t1;
    t_word w_t2;
    t_word w_s0;
    t_word w_s1;

    always_comb begin
        w_sig1 = f_rotr(i_vars[4], 6) ^ f_rotr(i_vars[4], 11) ^ f_rotr(i_vars[4], 25);
        w_ch   = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        w_sig0 = f_rotr(i_vars[0], 2) ^ f_rotr(i_vars[0], 13) ^ f_rotr(i_vars[0], 22);
        w_maj  = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        w_t1   = i_vars[7] + w_sig1 + w_ch + i_k + i_w[0];
        w_t2   = w_sig0 + w_maj;

        o_vars[0] = w_t1 + w_t2;
        o_vars[1] = i_vars[0];
        o_vars[2] = i_vars[1];
        o_vars[3] = i_vars[2];
        o_vars[4] = i_vars[3] + w_t1;
        o_vars[5] = i_vars[4];
        o_vars[6] = i_vars[5];
        o_vars[7] = i_vars[6];

        w_s0    = f_rotr(i_w[1], 7) ^ f_rotr(i_w[1], 18) ^ (i_w[1] >> 3);
        w_s1    = f_rotr(i_w[14], 17) ^ f_rotr(i_w[14], 19) ^ (i_w[14] >> 10);
        o_new_w = i_w[0] + w_s0 + i_w[9] + w_s1;
    end

endmodule

`default_nettype wire

[src/sha256_stream_hasher_unit.sv]
// Top level of the SHA-256 stream hasher: byte gathering, padding sequencer and digest output.
`default_nettype none

// Hashes a byte stream with standard SHA-256, one optional byte per input beat. A byte
// beat is taken whenever the input is ready. The byte that completes a 64-byte block is
// followed by a busy period: 64 rounds through the single round unit, one round per cycle,
// then a fold of the working variables into the chaining state. After a beat with last set,
// padding bytes are added one by one up to the end of the block, which is then hashed.
// When fewer than nine bytes of the block were free, another block of padding follows and
// is hashed as well. The eight digest words are then offered on the output channel, word 0
// first. The input is not ready from the acceptance of a block-ending or last beat until
// the busy period, and for a last beat the eighth digest word, is over.
module sha256_stream_hasher_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);
    import shs_pkg::*;

    t_state                 r_state, n_state;
    logic [C_COUNT_W-1:0]   r_count, n_count;
    logic [5:0]             r_pos, n_pos;
    logic [5:0]             r_t, n_t;
    logic [C_IDX_W-1:0]     r_oi, n_oi;
    logic                   r_fin, n_fin;
    logic                   r_pad_first, n_pad_first;
    logic                   r_final_blk, n_final_blk;
    logic                   r_last_blk, n_last_blk;
    t_vars                  r_h, n_h;
    t_vars                  r_v, n_v;
    t_sched                 r_w, n_w;
    logic [23:0]            r_acc, n_acc;

    logic                   w_in_acc;
    logic                   w_push;
    logic [C_BYTE_W-1:0]    w_byte;
    logic [C_BYTE_W-1:0]    w_pad_byte;
    logic [63:0]            w_len;
    logic [2:0]             w_sel;
    t_vars                  w_rvars;
    t_word                  w_new_w;

    shs_round u_round (
        .i_vars  (r_v),
        .i_w     (r_w),
        .i_k     (C_ROUND_K[r_t]),
        .o_vars  (w_rvars),
        .o_new_w (w_new_w)
    );

    assign i_in.ready        = (r_state == ST_IDLE);
    assign w_in_acc          = i_in.valid && i_in.ready;
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_h[r_oi];
    assign o_out.word_index  = r_oi;
    assign o_out.last_word   = (r_oi == C_IDX_LAST);

    assign w_len = {r_count, 3'b000};
    assign w_sel = 3'd7 - r_pos[2:0];

    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = C_PAD_BYTE;
        end else if (r_final_blk && (r_pos[5:3] == 3'b111)) begin
            w_pad_byte = w_len[{w_sel, 3'b000} +: 8];
        end else begin
            w_pad_byte = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_t         = r_t;
        n_oi        = r_oi;
        n_fin       = r_fin;
        n_pad_first = r_pad_first;
        n_final_blk = r_final_blk;
        n_last_blk  = r_last_blk;
        n_h         = r_h;
        n_v         = r_v;
        n_w         = r_w;
        n_acc       = r_acc;
        w_push      = 1'b0;
        w_byte      = w_pad_byte;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_fin       = i_in.last;
                    n_pad_first = i_in.last;
                    n_final_blk = 1'b0;
                    n_last_blk  = 1'b0;
                    if (i_in.byte_valid) begin
                        w_push  = 1'b1;
                        w_byte  = i_in.data_byte;
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.last && !(i_in.byte_valid && r_pos == C_POS_LAST)) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                w_push      = 1'b1;
                n_pad_first = 1'b0;
                if (r_pad_first && (r_pos[5:3] != 3'b111)) begin
                    n_final_blk = 1'b1;
                end
                if (r_pos == C_POS_LAST) begin
                    if (r_final_blk) begin
                        n_last_blk = 1'b1;
                    end else begin
                        n_final_blk = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                n_v = w_rvars;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_new_w;
                n_t     = r_t + 1'b1;
                if (r_t == C_POS_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                if (r_last_blk) begin
                    n_state = ST_OUT;
                    n_oi    = '0;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_oi = r_oi + 1'b1;
                    if (r_oi == C_IDX_LAST) begin
                        n_state     = ST_IDLE;
                        n_h         = C_IV;
                        n_count     = '0;
                        n_pos       = '0;
                        n_fin       = 1'b0;
                        n_pad_first = 1'b0;
                        n_final_blk = 1'b0;
                        n_last_blk  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_push) begin
            n_acc = {r_acc[15:0], w_byte};
            n_pos = r_pos + 1'b1;
            if (r_pos[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = {r_acc, w_byte};
            end
            if (r_pos == C_POS_LAST) begin
                n_state = ST_ROUND;
                n_t     = '0;
                n_v     = r_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_t         <= '0;
            r_oi        <= '0;
            r_fin       <= 1'b0;
            r_pad_first <= 1'b0;
            r_final_blk <= 1'b0;
            r_last_blk  <= 1'b0;
            r_h         <= C_IV;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_t         <= n_t;
            r_oi        <= n_oi;
            r_fin       <= n_fin;
            r_pad_first <= n_pad_first;
            r_final_blk <= n_final_blk;
            r_last_blk  <= n_last_blk;
            r_h         <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_w   <= n_w;
        r_acc <= n_acc;
    end

endmodule

`default_nettype wire

[src/shs_checker.sv]
// Port-level checks of the SHA-256 stream hasher and their binding to the top level.
`default_nettype none

module shs_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire shs_pkg::t_word             i_out_word,
    input wire logic [shs_pkg::C_IDX_W-1:0] i_out_idx,
    input wire logic                       i_out_last
);
    import shs_pkg::*;

    // A stalled digest beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_word) && $stable(i_out_idx))
        else $error("digest beat changed while stalled");

    // No new input is taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during digest output");

    // Digest words follow each other without gaps and in order.
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && (i_out_idx == $past(i_out_idx) + 3'd1))
        else $error("digest word sequence broken");

    // After the final word the block is idle and ready again.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid && i_in_ready)
        else $error("block not idle after final digest word");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_idx   (o_out.word_index),
    .i_out_last  (o_out.last_word)
);

`default_nettype wire
